// File: design/ffha_pkg.sv
package ffha_pkg;
  localparam int HeapBytes = 65536;
  localparam int MaxFree = 64;
  localparam int SlotW = $clog2(MaxFree);
  localparam int LinkW = SlotW + 1;
  localparam int SizeW = 17;
  localparam int HdrEntries = 8192;
  localparam int HdrW = $clog2(HdrEntries);

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoFit = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } ffha_in_t;

  typedef struct packed {
    logic [15:0] granted_address;
    logic [1:0]  status;
  } ffha_out_t;

  typedef struct packed {
    logic [15:0]      start;
    logic [SizeW-1:0] size;
    logic [LinkW-1:0] next;
  } ffha_blk_t;
endpackage

// File: design/ffha_hdr_mem.sv
module ffha_hdr_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ffha_pkg::HdrW-1:0]  waddr,
  input  logic [ffha_pkg::SizeW-1:0] wdata,
  input  logic [ffha_pkg::HdrW-1:0]  raddr,
  output logic [ffha_pkg::SizeW-1:0] rdata
);
  import ffha_pkg::*;

  logic [SizeW-1:0] mem [HdrEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/ffha_blk_mem.sv
module ffha_blk_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ffha_pkg::SlotW-1:0] waddr,
  input  ffha_pkg::ffha_blk_t        wdata,
  input  logic [ffha_pkg::SlotW-1:0] raddr,
  output ffha_pkg::ffha_blk_t        rdata
);
  import ffha_pkg::*;

  ffha_blk_t mem [MaxFree];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/first_fit_heap_allocator.sv
// First-fit heap allocator over a 64 KiB byte heap, free list of 64 slots.
// Input channel in_valid/in_ready/in_data carries one command transaction:
// allocate (request_bytes) or free (release_address). The output channel
// out_valid/out_ready/out_data returns exactly one result per command:
// granted address and status (ok, no block fits, free list table full).
// Commands are handled one at a time. An allocate walks the free list with
// one block-table memory read per list entry, each entry passing through
// S_RD and S_CHK, and examines at most 64 list entries. A free is paced by
// the header-size memory read. Slot occupancy lives in flip-flops.
// While reset is held, block-table entry 0 is written with the whole heap,
// so after reset the heap is one free block at slot 0; the header-size store
// is not cleared and needs no clearing pass. The result is held in an output
// register; while the receiver stalls, in_ready stays low and no new command
// is taken, so nothing is lost or reordered.
module first_fit_heap_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffha_pkg::ffha_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ffha_pkg::ffha_out_t out_data
);
  import ffha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_FRD   = 7'b0001000,
    S_FWR   = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  ffha_in_t req_r;
  logic [SizeW-1:0] need_r;
  logic [LinkW-1:0] cur_r, head_r, head_nxt;
  logic [SlotW:0] steps_r;
  logic [MaxFree-1:0] used_r, used_nxt;
  ffha_out_t res_r;
  logic [SlotW-1:0] free_slot;
  logic free_found;

  logic blk_we;
  logic [SlotW-1:0] blk_waddr, blk_raddr;
  ffha_blk_t blk_wdata, blk_rdata;
  logic hdr_we;
  logic [HdrW-1:0] hdr_waddr, hdr_raddr;
  logic [SizeW-1:0] hdr_wdata, hdr_rdata;
  logic [15:0] hdr_off;
  logic fits;

  ffha_blk_mem u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(blk_raddr), .rdata(blk_rdata)
  );
  ffha_hdr_mem u_hdr (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
    .raddr(hdr_raddr), .rdata(hdr_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;
  assign hdr_off   = req_r.release_address - 16'd8;
  assign hdr_raddr = hdr_off[15:3];
  assign blk_raddr = cur_r[SlotW-1:0];
  assign fits = used_r[cur_r[SlotW-1:0]] && (blk_rdata.size >= need_r + SizeW'(16));

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = MaxFree - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    used_nxt  = used_r;
    blk_we    = 1'b0;
    blk_waddr = cur_r[SlotW-1:0];
    blk_wdata = blk_rdata;
    hdr_we    = 1'b0;
    hdr_waddr = blk_rdata.start[15:3];
    hdr_wdata = need_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CmdAlloc) begin
            state_nxt = S_WAIT;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_WAIT: begin
        state_nxt = (cur_r < LinkW'(MaxFree)) ? S_RD : S_OUT;
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (fits) begin
          blk_we = 1'b1;
          blk_wdata.start = blk_rdata.start + need_r[15:0];
          blk_wdata.size  = blk_rdata.size - need_r;
          hdr_we = 1'b1;
          state_nxt = S_OUT;
        end else if (steps_r + 1'b1 >= (SlotW+1)'(MaxFree) ||
                     blk_rdata.next >= LinkW'(MaxFree)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_FRD: begin
        if (req_r.release_address == 16'd0 || !free_found) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        blk_we = 1'b1;
        blk_waddr = free_slot;
        blk_wdata.start = hdr_off;
        blk_wdata.size  = hdr_rdata;
        blk_wdata.next  = head_r;
        used_nxt[free_slot] = 1'b1;
        head_nxt = {1'b0, free_slot};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (!rst_n) begin
      blk_we    = 1'b1;
      blk_waddr = '0;
      blk_wdata = '{start: 16'd0, size: SizeW'(HeapBytes), next: LinkW'(MaxFree)};
      hdr_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      used_r  <= MaxFree'(1);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        req_r   <= in_data;
        need_r  <= SizeW'({in_data.request_bytes[15:3] +
                   13'(in_data.request_bytes[2:0] != 3'd0), 3'b000}) + SizeW'(8);
        if (in_data.request_bytes > 16'hFFF8) begin
          need_r <= SizeW'(65544);
        end
        cur_r   <= head_r;
        steps_r <= '0;
        res_r   <= '{granted_address: 16'd0, status: StatusNoFit};
      end
      S_CHK: begin
        if (fits) begin
          res_r <= '{granted_address: blk_rdata.start + 16'd8, status: StatusOk};
        end
        cur_r   <= blk_rdata.next;
        steps_r <= steps_r + 1'b1;
      end
      S_FRD: begin
        res_r <= '{granted_address: 16'd0,
                   status: (req_r.release_address != 16'd0 && !free_found)
                           ? StatusFull : StatusOk};
      end
      default: begin
      end
    endcase
  end
endmodule

// File: design/ffha_checker.sv
module ffha_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ffha_pkg::ffha_out_t out_data
);
  import ffha_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second command taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != StatusOk |-> out_data.granted_address == 16'd0)
    else $error("failure with nonzero address");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
